>>> rtl/edd_pkg.sv
// Shared types and constants of the error-diffusion dither block.
`default_nettype none
package edd_pkg;

    localparam int KROWS     = 3;
    localparam int KCOLS     = 5;
    localparam int CENTRE    = 2;
    localparam int FULL      = 255;
    localparam int COEF_BITS = 8;
    localparam int ROW_BITS  = KCOLS * COEF_BITS;

    // configuration register indexes (8-byte stride)
    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_SHIFT   = 3'd2,
        REG_DIVISOR = 3'd3,
        REG_COEF0   = 3'd4,
        REG_COEF1   = 3'd5,
        REG_COEF2   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [10:0]                          width;
        logic [15:0]                          height;
        logic                                 shift_mode;
        logic [15:0]                          divisor;
        logic [KROWS-1:0][ROW_BITS-1:0]       coef;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECIDE,
        ST_SLOT,
        ST_SCALE,
        ST_DIVWAIT,
        ST_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch_pix;
        logic decide;
        logic slot_first;
        logic slot_next;
        logic tgt_load;
        logic term_shift;
        logic term_zero;
        logic div_start;
        logic term_div;
        logic tgt_write;
        logic advance;
        logic sweep_step;
    } t_cmd;

    typedef struct packed {
        logic slot_valid;
        logic slot_last;
        logic shift_mode;
        logic div_zero;
        logic div_done;
        logic row_end;
        logic out_free;
        logic sweep_done;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/edd_if.sv
// Pixel and result channel interfaces.
`default_nettype none
interface edd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface edd_res_if;
    logic valid;
    logic ready;
    logic white;
    logic last_of_image;
    modport source (output valid, output white, output last_of_image, input ready);
    modport sink (input valid, input white, input last_of_image, output ready);
endinterface
`default_nettype wire

>>> rtl/edd_regs.sv
// APB configuration registers.
`default_nettype none
module edd_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [5:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output edd_pkg::t_cfg       o_cfg
);
    edd_pkg::t_cfg     r_cfg;
    edd_pkg::t_reg_idx idx;
    logic              wr;

    assign idx    = edd_pkg::t_reg_idx'(paddr[5:3]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width      <= 11'd640;
            r_cfg.height     <= 16'd480;
            r_cfg.shift_mode <= 1'b1;
            r_cfg.divisor    <= 16'd4;
            r_cfg.coef[0]    <= 40'd117440512;
            r_cfg.coef[1]    <= 40'd17105664;
            r_cfg.coef[2]    <= 40'd0;
        end else if (wr) begin
            unique case (idx)
                edd_pkg::REG_WIDTH:   r_cfg.width      <= pwdata[10:0];
                edd_pkg::REG_HEIGHT:  r_cfg.height     <= pwdata[15:0];
                edd_pkg::REG_SHIFT:   r_cfg.shift_mode <= pwdata[0];
                edd_pkg::REG_DIVISOR: r_cfg.divisor    <= pwdata[15:0];
                edd_pkg::REG_COEF0:   r_cfg.coef[0]    <= pwdata[39:0];
                edd_pkg::REG_COEF1:   r_cfg.coef[1]    <= pwdata[39:0];
                edd_pkg::REG_COEF2:   r_cfg.coef[2]    <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            edd_pkg::REG_WIDTH:   prdata = {53'd0, r_cfg.width};
            edd_pkg::REG_HEIGHT:  prdata = {48'd0, r_cfg.height};
            edd_pkg::REG_SHIFT:   prdata = {63'd0, r_cfg.shift_mode};
            edd_pkg::REG_DIVISOR: prdata = {48'd0, r_cfg.divisor};
            edd_pkg::REG_COEF0:   prdata = {24'd0, r_cfg.coef[0]};
            edd_pkg::REG_COEF1:   prdata = {24'd0, r_cfg.coef[1]};
            edd_pkg::REG_COEF2:   prdata = {24'd0, r_cfg.coef[2]};
            default:              prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/edd_div.sv
// Bit-serial signed divider for weighted error terms.
`default_nettype none
module edd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [23:0]        i_num,
    input  wire logic [15:0]        i_den,
    input  wire logic               i_neg,
    output logic                    o_done,
    output logic signed [23:0]      o_quo
);
    logic [23:0] r_num;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic        qbit;

    // restoring step: one quotient bit per cycle, shifted into r_num
    assign trial = {r_rem, r_num[23]};
    assign qbit  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= qbit ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_num <= {r_num[22:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_num) : $signed(r_num);

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (!r_done && r_busy))
        else $error("divider reported done right after start");
endmodule
`default_nettype wire

>>> rtl/edd_dpath.sv
// Datapath: error memory, gray/threshold, kernel walk, scaling, clearing sweep.
`default_nettype none
module edd_dpath #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire edd_pkg::t_cfg  i_cfg,
    input  wire edd_pkg::t_cmd  i_cmd,
    output edd_pkg::t_sts       o_sts,
    input  wire logic [7:0]     i_red,
    input  wire logic [7:0]     i_green,
    input  wire logic [7:0]     i_blue,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_white,
    output logic                o_last
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = edd_pkg::KROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    // position state
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [1:0]    r_base;

    logic [CW:0]   width_eff;
    logic [15:0]   height_eff;

    // error memory
    logic [15:0]   r_mem [DEPTH];
    logic [15:0]   r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    // pixel
    logic [7:0]         mx, mn, r_gray;
    logic signed [16:0] value;
    logic               white_d;
    logic signed [16:0] err_d;
    logic signed [15:0] r_err;
    logic               r_white;

    // kernel walk
    logic [1:0]          r_ki;
    logic [2:0]          r_kj;
    logic [7:0]          coef;
    logic                row_ok, left_ok, tc_ok, centre_ok, slot_valid;
    logic [CW:0]         colj, tc_w;
    logic [2:0]          tsum;
    logic [1:0]          trow;
    logic [AW-1:0]       cur_addr, tgt_addr;
    logic signed [24:0]  prod_full;
    logic signed [23:0]  r_prod;
    logic signed [23:0]  r_term;
    logic [AW-1:0]       r_taddr;
    logic [1:0]          r_trow;
    logic [CW-1:0]       r_tc;
    logic [CW:0]         tc1;
    logic [4:0]          sh;
    logic [23:0]         mag;
    logic                div_done;
    logic signed [23:0]  div_quo;
    logic signed [24:0]  sum;
    logic [15:0]         sat;

    // clearing sweep, r_hw marks one past the highest column written per row
    logic [CW:0]   r_hw [edd_pkg::KROWS];
    logic [1:0]    r_sw_row;
    logic [CW:0]   r_sw_col;
    logic          r_sw_all;
    logic [CW:0]   sw_hw;
    logic          sw_active;
    logic [AW-1:0] sw_addr;

    logic          row_end, image_end;
    logic          r_out_valid, r_out_white, r_out_last;
    logic          out_free;

    always_comb begin
        if (i_cfg.width == '0)
            width_eff = (CW+1)'(1);
        else if (32'(i_cfg.width) > MAX_WIDTH)
            width_eff = (CW+1)'(MAX_WIDTH);
        else
            width_eff = (CW+1)'(i_cfg.width);
        height_eff = (i_cfg.height == '0) ? 16'd1 : i_cfg.height;
    end

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
    end

    assign cur_addr = AW'(32'(r_base) * MAX_WIDTH + 32'(r_col));

    // threshold: 2*v < 255 is v <= 127
    assign value   = $signed({9'd0, r_gray}) + $signed({r_rdata[15], r_rdata});
    assign white_d = value >= 17'sd128;
    assign err_d   = white_d ? value - 17'sd255 : value;

    // kernel slot qualification
    assign coef      = i_cfg.coef[r_ki][edd_pkg::COEF_BITS*r_kj +: edd_pkg::COEF_BITS];
    assign row_ok    = ({1'b0, r_row} + 17'(r_ki)) < {1'b0, height_eff};
    assign centre_ok = !(r_ki == 2'd0 && 32'(r_kj) <= edd_pkg::CENTRE);
    assign colj      = (CW+1)'(r_col) + (CW+1)'(r_kj);
    assign left_ok   = 32'(colj) >= edd_pkg::CENTRE;
    assign tc_w      = colj - (CW+1)'(edd_pkg::CENTRE);
    assign tc_ok     = tc_w < width_eff;
    assign slot_valid = row_ok && (coef != '0) && centre_ok && left_ok && tc_ok;
    assign tsum      = 3'(r_base) + 3'(r_ki);
    assign trow      = (32'(tsum) >= edd_pkg::KROWS) ? 2'(tsum - 3'(edd_pkg::KROWS))
                                                     : tsum[1:0];
    assign tgt_addr  = AW'(32'(trow) * MAX_WIDTH + 32'(tc_w[CW-1:0]));
    assign prod_full = r_err * $signed({1'b0, coef});

    assign sh  = (|i_cfg.divisor[15:5]) ? 5'd31 : i_cfg.divisor[4:0];
    assign mag = r_prod[23] ? 24'(-r_prod) : r_prod;

    edd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (mag),
        .i_den   (i_cfg.divisor),
        .i_neg   (r_prod[23]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign sum = $signed({{9{r_rdata[15]}}, r_rdata}) + $signed({r_term[23], r_term});
    always_comb begin
        if (sum > 25'sd32767)
            sat = 16'h7fff;
        else if (sum < -25'sd32768)
            sat = 16'h8000;
        else
            sat = sum[15:0];
    end
    assign tc1 = (CW+1)'(r_tc) + (CW+1)'(1);

    always_comb begin
        sw_hw = '0;
        for (int k = 0; k < edd_pkg::KROWS; k++) begin
            if (r_sw_row == 2'(k)) sw_hw = r_hw[k];
        end
    end
    assign sw_active = r_sw_col < sw_hw;
    assign sw_addr   = AW'(32'(r_sw_row) * MAX_WIDTH + 32'(r_sw_col[CW-1:0]));

    // single write port shared by the kernel update and the sweep
    assign rd_en     = i_cmd.latch_pix | i_cmd.tgt_load;
    assign rd_addr   = i_cmd.latch_pix ? cur_addr : tgt_addr;
    assign mem_we    = i_cmd.tgt_write | (i_cmd.sweep_step & sw_active);
    assign mem_waddr = i_cmd.tgt_write ? r_taddr : sw_addr;
    assign mem_wdata = i_cmd.tgt_write ? sat : 16'd0;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (rd_en)  r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pix) r_gray <= 8'(({1'b0, mn} + {1'b0, mx}) >> 1);
        if (i_cmd.decide) begin
            r_err   <= err_d[15:0];
            r_white <= white_d;
        end
        if (i_cmd.tgt_load) begin
            r_prod  <= prod_full[23:0];
            r_taddr <= tgt_addr;
            r_trow  <= trow;
            r_tc    <= tc_w[CW-1:0];
        end
        if (i_cmd.term_shift)
            r_term <= r_prod >>> sh;
        else if (i_cmd.term_zero)
            r_term <= '0;
        else if (i_cmd.term_div)
            r_term <= div_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ki <= '0;
            r_kj <= '0;
        end else if (i_cmd.slot_first) begin
            r_ki <= '0;
            r_kj <= '0;
        end else if (i_cmd.slot_next) begin
            if (32'(r_kj) == edd_pkg::KCOLS - 1) begin
                r_kj <= '0;
                r_ki <= r_ki + 2'd1;
            end else begin
                r_kj <= r_kj + 3'd1;
            end
        end
    end

    assign row_end   = ({1'b0, r_col} + (CW+1)'(1)) >= width_eff;
    assign image_end = row_end && (({1'b0, r_row} + 17'd1) >= {1'b0, height_eff});
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_base   <= '0;
            r_sw_row <= '0;
            r_sw_col <= '0;
            r_sw_all <= 1'b1;
        end else if (i_cmd.advance) begin
            r_sw_col <= '0;
            if (image_end) begin
                r_col    <= '0;
                r_row    <= '0;
                r_base   <= '0;
                r_sw_row <= '0;
                r_sw_all <= 1'b1;
            end else if (row_end) begin
                r_col    <= '0;
                r_row    <= r_row + 16'd1;
                r_base   <= (32'(r_base) == edd_pkg::KROWS - 1) ? 2'd0 : r_base + 2'd1;
                r_sw_row <= r_base;
                r_sw_all <= 1'b0;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end else if (i_cmd.sweep_step) begin
            if (sw_active) begin
                r_sw_col <= r_sw_col + (CW+1)'(1);
            end else if (r_sw_all && 32'(r_sw_row) != edd_pkg::KROWS - 1) begin
                r_sw_row <= r_sw_row + 2'd1;
                r_sw_col <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < edd_pkg::KROWS; k++) r_hw[k] <= (CW+1)'(MAX_WIDTH);
        end else begin
            for (int k = 0; k < edd_pkg::KROWS; k++) begin
                if (i_cmd.tgt_write && r_trow == 2'(k) && tc1 > r_hw[k])
                    r_hw[k] <= tc1;
                else if (i_cmd.sweep_step && !sw_active && r_sw_row == 2'(k))
                    r_hw[k] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_out_white <= r_white;
            r_out_last  <= image_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_white     = r_out_white;
    assign o_last      = r_out_last;

    always_comb begin
        o_sts.slot_valid = slot_valid;
        o_sts.slot_last  = (32'(r_ki) == edd_pkg::KROWS - 1) && (32'(r_kj) == edd_pkg::KCOLS - 1);
        o_sts.shift_mode = i_cfg.shift_mode;
        o_sts.div_zero   = i_cfg.divisor == '0;
        o_sts.div_done   = div_done;
        o_sts.row_end    = row_end;
        o_sts.out_free   = out_free;
        o_sts.sweep_done = !sw_active && (!r_sw_all || 32'(r_sw_row) == edd_pkg::KROWS - 1);
    end

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.tgt_write && i_cmd.sweep_step))
        else $error("kernel update and sweep both drive the write port");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) < edd_pkg::KROWS && 32'(r_sw_row) < edd_pkg::KROWS)
        else $error("buffer row pointer out of range");
endmodule
`default_nettype wire

>>> rtl/edd_ctrl.sv
// Controller: sequences one pixel through lookup, kernel walk and row clearing.
`default_nettype none
module edd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire edd_pkg::t_sts  i_sts,
    output edd_pkg::t_cmd       o_cmd
);
    edd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= edd_pkg::ST_SWEEP;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edd_pkg::ST_SWEEP:   if (i_sts.sweep_done) n_state = edd_pkg::ST_IDLE;
            edd_pkg::ST_IDLE:    if (i_in_valid) n_state = edd_pkg::ST_DECIDE;
            edd_pkg::ST_DECIDE:  n_state = edd_pkg::ST_SLOT;
            edd_pkg::ST_SLOT: begin
                if (i_sts.slot_valid)     n_state = edd_pkg::ST_SCALE;
                else if (i_sts.slot_last) n_state = edd_pkg::ST_FINISH;
            end
            edd_pkg::ST_SCALE: begin
                if (i_sts.shift_mode || i_sts.div_zero) n_state = edd_pkg::ST_WRITE;
                else                                    n_state = edd_pkg::ST_DIVWAIT;
            end
            edd_pkg::ST_DIVWAIT: if (i_sts.div_done) n_state = edd_pkg::ST_WRITE;
            edd_pkg::ST_WRITE: begin
                n_state = i_sts.slot_last ? edd_pkg::ST_FINISH : edd_pkg::ST_SLOT;
            end
            edd_pkg::ST_FINISH: begin
                if (i_sts.out_free)
                    n_state = i_sts.row_end ? edd_pkg::ST_SWEEP : edd_pkg::ST_IDLE;
            end
            default: n_state = edd_pkg::ST_SWEEP;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            edd_pkg::ST_SWEEP: o_cmd.sweep_step = 1'b1;
            edd_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_pix = i_in_valid;
            end
            edd_pkg::ST_DECIDE: begin
                o_cmd.decide     = 1'b1;
                o_cmd.slot_first = 1'b1;
            end
            edd_pkg::ST_SLOT: begin
                if (i_sts.slot_valid)      o_cmd.tgt_load  = 1'b1;
                else if (!i_sts.slot_last) o_cmd.slot_next = 1'b1;
            end
            edd_pkg::ST_SCALE: begin
                if (i_sts.shift_mode)    o_cmd.term_shift = 1'b1;
                else if (i_sts.div_zero) o_cmd.term_zero  = 1'b1;
                else                     o_cmd.div_start  = 1'b1;
            end
            edd_pkg::ST_DIVWAIT: o_cmd.term_div = i_sts.div_done;
            edd_pkg::ST_WRITE: begin
                o_cmd.tgt_write = 1'b1;
                o_cmd.slot_next = !i_sts.slot_last;
            end
            edd_pkg::ST_FINISH: o_cmd.advance = i_sts.out_free;
            default: ;
        endcase
    end

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.advance |-> i_sts.out_free)
        else $error("result loaded over an untaken result");
endmodule
`default_nettype wire

>>> rtl/error_diffusion_dither_top.sv
// Top level of the error-diffusion dither block.
`default_nettype none
// Dithers RGB pixels, taken in raster order, to black or white, one result per
// pixel. Pixels are handled one at a time: a pixel walks the 15 kernel slots,
// and each slot that really updates the error store is scaled by a shift in
// shift mode, or in division mode by the bit-serial divider (one quotient bit
// per cycle). At the end of each row the finished error row is swept to zero,
// one entry a cycle up to the highest column written; at the end of an image
// all three rows are swept, and after reset the whole store (3*MAX_WIDTH
// entries) is cleared while no pixel is taken. Configuration writes are taken
// at any time and act at once, but belong between images or while the block
// is idle.
module error_diffusion_dither_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    edd_pix_if.sink             i_pix,
    edd_res_if.source           o_res,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [5:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    edd_pkg::t_cfg cfg;
    edd_pkg::t_cmd cmd;
    edd_pkg::t_sts sts;

    edd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    edd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    edd_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_red       (i_pix.red),
        .i_green     (i_pix.green),
        .i_blue      (i_pix.blue),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_white     (o_res.white),
        .o_last      (o_res.last_of_image)
    );
endmodule
`default_nettype wire

>>> bench/error_diffusion_dither_top_test.sv
// Self-checking testbench for the error-diffusion dither block.
`timescale 1ns / 100ps
module error_diffusion_dither_top_test;

    localparam int MAXW        = 1024;
    localparam int SETTLE      = 3300;     // covers the full store sweep
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic white;
        logic last_of_image;
    } t_level;

    class dither_scoreboard;
        t_level levels_due[$];
        int     mismatches;

        function new();
            levels_due = {};
            mismatches = 0;
        endfunction

        function void note_pixel(t_level lvl);
            levels_due = {levels_due, lvl};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_level(t_level got);
            t_level want;
            if (levels_due.size() == 0) begin
                report("result with no pixel outstanding");
                return;
            end
            want = levels_due.pop_front();
            if (got.white !== want.white)
                report($sformatf("white got %b want %b", got.white, want.white));
            if (got.last_of_image !== want.last_of_image)
                report($sformatf("last_of_image got %b want %b",
                                 got.last_of_image, want.last_of_image));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;

    edd_pix_if pix ();
    edd_res_if res ();

    error_diffusion_dither_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dither_scoreboard sb = new();

    // predictor copy of registers and error store
    logic [10:0]  cfg_width;
    logic [15:0]  cfg_height;
    logic         cfg_shift;
    logic [15:0]  cfg_divisor;
    logic [39:0]  cfg_coef [edd_pkg::KROWS];
    shortint      err_store [edd_pkg::KROWS*MAXW];
    int           col_cnt, row_cnt, row_base;

    int era;              // 0: sender sparse idle, 1: receiver sparse idle, 2: no idling
    bit hold_request;
    int hold_left;
    int cycle_count;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random backpressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && hold_left == 0 && res.ready) begin
            res.ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end else begin
            case (era)
                0: res.ready <= ($urandom_range(99) >= 86);
                1: res.ready <= ($urandom_range(99) >= 8);
                default: res.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_level('{white: res.white, last_of_image: res.last_of_image});
    end

    task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int w, h, col, mx, mn, val, e, p, t, tc, s, v, idx;
        logic [7:0] c;
        bit wh, row_end, img_end;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        col = (col_cnt >= MAXW) ? MAXW - 1 : col_cnt;
        val = ((mn + mx) >> 1) + err_store[row_base * MAXW + col];
        wh = !(2 * val < edd_pkg::FULL);
        e = val - (wh ? edd_pkg::FULL : 0);
        for (int i = 0; i < edd_pkg::KROWS; i++) begin
            if (row_cnt + i >= h) continue;
            for (int j = 0; j < edd_pkg::KCOLS; j++) begin
                c = cfg_coef[i][8*j +: 8];
                if (c == 0) continue;
                if (i == 0 && j <= edd_pkg::CENTRE) continue;
                if (col + j < edd_pkg::CENTRE) continue;
                tc = col + j - edd_pkg::CENTRE;
                if (tc >= w) continue;
                p = e * int'(c);
                if (cfg_shift) begin
                    s = (cfg_divisor > 31) ? 31 : cfg_divisor;
                    t = p >>> s;
                end else begin
                    t = (cfg_divisor == 0) ? 0 : p / int'(cfg_divisor);
                end
                idx = ((row_base + i) % edd_pkg::KROWS) * MAXW + tc;
                v = int'(err_store[idx]) + t;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                err_store[idx] = shortint'(v);
            end
        end
        row_end = (col + 1 >= w);
        img_end = row_end && (row_cnt + 1 >= h);
        if (img_end) begin
            foreach (err_store[k]) err_store[k] = 0;
            col_cnt = 0;
            row_cnt = 0;
            row_base = 0;
        end else if (row_end) begin
            for (int k = 0; k < MAXW; k++) err_store[row_base * MAXW + k] = 0;
            row_base = (row_base + 1) % edd_pkg::KROWS;
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 16'hFFFF;
        end else begin
            col_cnt = col + 1;
        end
        sb.note_pixel('{white: wh, last_of_image: img_end});
    endtask

    task automatic apb_write(edd_pkg::t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [10:0] w, logic [15:0] h, logic sm, logic [15:0] dv,
                              logic [39:0] c0, logic [39:0] c1, logic [39:0] c2);
        pix.valid <= 1'b0;
        wait (sb.levels_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        apb_write(edd_pkg::REG_WIDTH, 64'(w));
        apb_write(edd_pkg::REG_HEIGHT, 64'(h));
        apb_write(edd_pkg::REG_SHIFT, 64'(sm));
        apb_write(edd_pkg::REG_DIVISOR, 64'(dv));
        apb_write(edd_pkg::REG_COEF0, 64'(c0));
        apb_write(edd_pkg::REG_COEF1, 64'(c1));
        apb_write(edd_pkg::REG_COEF2, 64'(c2));
        cfg_width = w; cfg_height = h; cfg_shift = sm; cfg_divisor = dv;
        cfg_coef[0] = c0; cfg_coef[1] = c1; cfg_coef[2] = c2;
    endtask

    // holds valid across back-to-back transfers, drops it only for a gap
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (era == 0 ? ($urandom_range(99) < 8) :
               era == 1 ? ($urandom_range(99) < 86) : 1'b0) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        do @(posedge i_clk); while (!pix.ready);
        predict_pixel(r, g, b);
    endtask

    function automatic logic [39:0] rand_kernel_row();
        logic [39:0] row;
        for (int j = 0; j < edd_pkg::KCOLS; j++) begin
            case ($urandom_range(5))
                0, 1: row[8*j +: 8] = 8'd0;
                2: row[8*j +: 8] = 8'hFF;
                default: row[8*j +: 8] = 8'($urandom);
            endcase
        end
        return row;
    endfunction

    initial begin
        logic [10:0] w;
        logic [15:0] h, dv;
        logic sm;
        era = 0;
        hold_request = 0;
        hold_left = 0;
        cycle_count = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        pix.valid <= 1'b0; pix.red <= '0; pix.green <= '0; pix.blue <= '0;
        foreach (err_store[k]) err_store[k] = 0;
        col_cnt = 0; row_cnt = 0; row_base = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default kernel plus a third row of ones, extremes of each channel
        set_config(11'd3, 16'd3, 1'b1, 16'd4, 40'h0007000000, 40'h0001050300,
                   40'h0101010101);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd55, 8'd100);
        send_pixel(8'd64, 8'd192, 8'd1);
        // zero width, zero height, division by zero
        set_config(11'd0, 16'd0, 1'b0, 16'd0, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF,
                   40'hFFFFFFFFFF);
        send_pixel(8'd100, 8'd100, 8'd100);
        send_pixel(8'd200, 8'd200, 8'd200);
        // largest divisor
        set_config(11'd2, 16'd2, 1'b0, 16'hFFFF, 40'hFFFFFFFFFF, 40'hFF00FF00FF, 40'd0);
        for (int k = 0; k < 4; k++) send_pixel(8'd90, 8'd170, 8'd30);
        // shift beyond 31, then zero shift to drive the store into saturation
        set_config(11'd2, 16'd1, 1'b1, 16'd40, 40'hFFFFFFFFFF, 40'd0, 40'd0);
        send_pixel(8'd120, 8'd120, 8'd120);
        send_pixel(8'd10, 8'd10, 8'd10);
        set_config(11'd5, 16'd2, 1'b1, 16'd0, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'd0);
        for (int k = 0; k < 8; k++) send_pixel(8'd255, 8'd250, 8'd240);

        for (int ph = 0; ph < 12; ph++) begin
            era = ph / 4;
            case (ph)
                3: begin w = 11'h7FF; h = 16'hFFFF; end
                7: begin w = 11'd1024; h = 16'd0; end
                default: begin
                    w = 11'($urandom_range(1, 12));
                    h = 16'($urandom_range(1, 6));
                end
            endcase
            sm = 1'($urandom);
            if (sm)
                dv = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            else
                dv = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
            set_config(w, h, sm, dv, rand_kernel_row(), rand_kernel_row(),
                       rand_kernel_row());
            if (ph == 8) hold_request = 1;
            for (int k = 0; k < 45; k++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        @(posedge i_clk);
        pix.valid <= 1'b0;

        wait (sb.levels_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.levels_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
